// ----- rtl/core/rte_pkg.sv -----
// ----------------------------------------------------------------------------
// rte_pkg
// Shared types and constants for the rotary encoder with push button.
// ----------------------------------------------------------------------------
`default_nettype none

package rte_pkg;

  // Width of the wrapping step counter (valid range 4..32)
  localparam int COUNT_WIDTH = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_DIRECTION_MODE = 1'b0;  // register index, taken from paddr[2]

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Rotation codes
  localparam logic [2:0] ROT_NONE     = 3'd0;
  localparam logic [2:0] ROT_INC      = 3'd1;
  localparam logic [2:0] ROT_DEC      = 3'd2;
  localparam logic [2:0] ROT_INC_HELD = 3'd3;
  localparam logic [2:0] ROT_DEC_HELD = 3'd4;
  localparam logic [2:0] ROT_CLICK    = 3'd5;

  // Button machine states
  typedef enum logic [1:0] {
    BTN_IDLE      = 2'd0,
    BTN_PRESSED   = 2'd1,
    BTN_CLICKED   = 2'd2,
    BTN_HELD_TURN = 2'd3
  } btn_state_t;

  // Input transaction
  typedef struct packed {
    logic operation;
    logic pin_a;
    logic pin_b;
    logic pin_button;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic        [2:0]  rotation;
    logic signed [15:0] step_difference;
    logic        [15:0] position;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/rte_state.sv -----
// ----------------------------------------------------------------------------
// rte_state
// Encoder counter, last-read snapshot and button machine; builds the result
// of a status read from the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_state (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               proc,
  input  wire rte_pkg::in_item_t  item,
  input  wire logic               direction_mode,
  output rte_pkg::out_item_t      result
);

  localparam int CW = rte_pkg::COUNT_WIDTH;

  logic [CW-1:0]        step_count_r, step_count_nxt;
  logic [CW-1:0]        last_read_r, last_read_nxt;
  logic                 prev_a_r, prev_a_nxt;
  rte_pkg::btn_state_t  btn_r, btn_nxt;

  logic [CW-1:0]        diff;
  logic                 neg;
  logic                 up;
  logic [2:0]           code;

  // Difference since last read and its sign
  assign diff = step_count_r - last_read_r;
  assign neg  = diff[CW-1];
  assign up   = direction_mode ? item.pin_b : ~item.pin_b;

  // Rotation code for a status read
  always_comb begin
    if (btn_r == rte_pkg::BTN_CLICKED) begin
      code = rte_pkg::ROT_CLICK;
    end else if (diff == '0) begin
      code = rte_pkg::ROT_NONE;
    end else if (neg) begin
      code = (btn_r == rte_pkg::BTN_HELD_TURN) ? rte_pkg::ROT_DEC_HELD : rte_pkg::ROT_DEC;
    end else begin
      code = (btn_r == rte_pkg::BTN_HELD_TURN) ? rte_pkg::ROT_INC_HELD : rte_pkg::ROT_INC;
    end
  end

  // Result fields: difference sign-extended, position zero-extended
  always_comb begin
    result.rotation        = code;
    result.step_difference = 16'(32'(signed'(diff)));
    result.position        = 16'(32'(step_count_r));
  end

  // Next state for counter, snapshot, A history and button machine
  always_comb begin
    step_count_nxt = step_count_r;
    last_read_nxt  = last_read_r;
    prev_a_nxt     = prev_a_r;
    btn_nxt        = btn_r;
    if (proc) begin
      if (item.operation == rte_pkg::OP_READ) begin
        last_read_nxt = step_count_r;
        if (btn_r == rte_pkg::BTN_CLICKED) begin
          btn_nxt = rte_pkg::BTN_IDLE;
        end
      end else if (item.pin_a != prev_a_r) begin
        prev_a_nxt = item.pin_a;
        if (!item.pin_a) begin
          if (!item.pin_button) begin
            btn_nxt = rte_pkg::BTN_HELD_TURN;
          end
          step_count_nxt = up ? step_count_r + CW'(1) : step_count_r - CW'(1);
        end
      end else begin
        unique case (btn_r)
          rte_pkg::BTN_HELD_TURN: begin
            if (item.pin_button) btn_nxt = rte_pkg::BTN_IDLE;
          end
          rte_pkg::BTN_IDLE: begin
            if (!item.pin_button) btn_nxt = rte_pkg::BTN_PRESSED;
          end
          rte_pkg::BTN_PRESSED: begin
            if (item.pin_button) btn_nxt = rte_pkg::BTN_CLICKED;
          end
          default: begin
            btn_nxt = btn_r;
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= '0;
      last_read_r  <= '0;
      prev_a_r     <= 1'b1;
      btn_r        <= rte_pkg::BTN_IDLE;
    end else begin
      step_count_r <= step_count_nxt;
      last_read_r  <= last_read_nxt;
      prev_a_r     <= prev_a_nxt;
      btn_r        <= btn_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rotary_encoder_with_button.sv -----
// ----------------------------------------------------------------------------
// rotary_encoder_with_button
// Quadrature encoder decoder with push button: pin samples move a wrapping
// step counter and a button machine, status reads return rotation data.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | in_item_t (operation, pins)
//   out_    | output    | out_valid / out_stall| out_item_t (rotation, diff, pos)
//   cfg     | input     | APB psel/penable     | direction_mode at byte 0
//
// One transaction per clock while in_stall is low. A transaction lands in the
// input register and is processed from there; a status read's result is
// loaded into the output register at the end of the cycle in which it is
// processed, and is offered on out_valid from then on.
// A sample never waits; a read waits in the input register only while the
// output register holds an untaken result. Synchronous reset, no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_with_button (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire rte_pkg::in_item_t                  in_data,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output rte_pkg::out_item_t                      out_data,
  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [rte_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [rte_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [rte_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                    pready
);

  logic                in_valid_r;
  rte_pkg::in_item_t   in_data_r;
  logic                out_valid_r;
  rte_pkg::out_item_t  out_data_r;
  logic                direction_mode_r;
  logic                advance;
  logic                out_load;
  logic                cfg_wr;
  rte_pkg::out_item_t  result;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready &
                  (paddr[2] == rte_pkg::REG_DIRECTION_MODE);
  assign prdata = (paddr[2] == rte_pkg::REG_DIRECTION_MODE) ?
                  {{(rte_pkg::CFG_DATA_W-1){1'b0}}, direction_mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_mode_r <= 1'b1;
    end else if (cfg_wr) begin
      direction_mode_r <= pwdata[0];
    end
  end

  // Held transaction moves on when it is a sample or the result slot frees up
  assign advance  = in_valid_r &
                    ((in_data_r.operation == rte_pkg::OP_SAMPLE) | ~out_valid_r | ~out_stall);
  assign out_load = advance & (in_data_r.operation == rte_pkg::OP_READ);
  assign in_stall = in_valid_r & ~advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // Processing logic and state
  rte_state u_state (
    .clk            (clk),
    .rst_n          (rst_n),
    .proc           (advance),
    .item           (in_data_r),
    .direction_mode (direction_mode_r),
    .result         (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- tb/rotary_encoder_with_button_checker.sv -----
// ----------------------------------------------------------------------------
// rotary_encoder_with_button_checker
// Watches the input, result and APB ports of the encoder block, tracks its
// counter and button machine, and scores every status report field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_with_button_checker
  import rte_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire in_item_t              in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire out_item_t             out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  input  wire logic [CFG_DATA_W-1:0] prdata,
  input  wire logic                  pready,
  output int unsigned                mismatch_count,
  output int unsigned                pending_results
);

  timeunit 1ns;
  timeprecision 1ps;

  // Tracked encoder state
  logic [COUNT_WIDTH-1:0] step_count;
  logic [COUNT_WIDTH-1:0] last_read_count;
  logic                   prev_a;
  btn_state_t             button;
  logic                   dir_mode;

  out_item_t   status_reports_q[$];
  int unsigned mismatches = 0;
  int unsigned pending = 0;

  assign mismatch_count  = mismatches;
  assign pending_results = pending;

  task automatic log_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: ERROR %s", $realtime, msg);
  endtask

  task automatic compare_field(string name, logic [31:0] expv, logic [31:0] gotv);
    if (gotv !== expv)
      log_failure($sformatf("%s expected %0h, got %0h", name, expv, gotv));
  endtask

  // Pin sample: falling A steps the counter, button machine advances
  task automatic apply_sample(in_item_t t);
    logic up;
    if (t.pin_a != prev_a) begin
      prev_a = t.pin_a;
      if (!t.pin_a) begin
        if (!t.pin_button) button = BTN_HELD_TURN;
        up = dir_mode ? t.pin_b : !t.pin_b;
        step_count = up ? step_count + 1'b1 : step_count - 1'b1;
      end
    end else if (button == BTN_HELD_TURN) begin
      if (t.pin_button) button = BTN_IDLE;
    end else begin
      if (button == BTN_IDLE && !t.pin_button) button = BTN_PRESSED;
      if (button == BTN_PRESSED && t.pin_button) button = BTN_CLICKED;
    end
  endtask

  // Status read: difference since last read, position, rotation code
  function automatic out_item_t report_status();
    logic [COUNT_WIDTH-1:0] diff;
    logic [63:0]            wide_diff;
    logic [63:0]            wide_pos;
    out_item_t              r;
    diff            = step_count - last_read_count;
    last_read_count = step_count;
    wide_diff       = {{(64-COUNT_WIDTH){diff[COUNT_WIDTH-1]}}, diff};
    wide_pos        = 64'(step_count);
    if (button == BTN_CLICKED) begin
      // a pending click wins over rotation and clears the button
      button     = BTN_IDLE;
      r.rotation = ROT_CLICK;
    end else if (diff == '0) begin
      r.rotation = ROT_NONE;
    end else if (diff[COUNT_WIDTH-1]) begin
      r.rotation = (button == BTN_HELD_TURN) ? ROT_DEC_HELD : ROT_DEC;
    end else begin
      r.rotation = (button == BTN_HELD_TURN) ? ROT_INC_HELD : ROT_INC;
    end
    r.step_difference = wide_diff[15:0];
    r.position        = wide_pos[15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      step_count      = '0;
      last_read_count = '0;
      prev_a          = 1'b1;
      button          = BTN_IDLE;
      dir_mode        = 1'b1;
      status_reports_q.delete();
    end else begin
      // register access
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_DIRECTION_MODE) dir_mode = pwdata[0];
        end else if (paddr[2] == REG_DIRECTION_MODE) begin
          compare_field("direction_mode readback", {{(CFG_DATA_W-1){1'b0}}, dir_mode},
                        prdata);
        end
      end
      // result transaction against the oldest pending report
      if (out_valid && !out_stall) begin
        if (status_reports_q.size() == 0) begin
          log_failure($sformatf("unexpected result %0h", out_data));
        end else begin
          want = status_reports_q.pop_front();
          compare_field("rotation", 32'(want.rotation), 32'(out_data.rotation));
          compare_field("step_difference", 32'(want.step_difference[15:0]),
                        32'(out_data.step_difference[15:0]));
          compare_field("position", 32'(want.position), 32'(out_data.position));
        end
      end
      // input transaction
      if (in_valid && !in_stall) begin
        if (in_data.operation == OP_READ) status_reports_q.push_back(report_status());
        else apply_sample(in_data);
      end
    end
    pending = status_reports_q.size();
  end

endmodule

`default_nettype wire

// ----- tb/rotary_encoder_with_button_tb.sv -----
// ----------------------------------------------------------------------------
// rotary_encoder_with_button_tb
// Drives pin samples, status reads and register accesses into the encoder
// block through directed (with a counter wrap below zero), random, idle and
// backpressure phases; the checker scores results, this top gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_with_button_tb;

  import rte_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [CFG_ADDR_W-1:0] DIR_MODE_ADDR = {REG_DIRECTION_MODE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR    = {~REG_DIRECTION_MODE, 2'b00};

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned mismatch_count;
  int unsigned pending_results;

  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_req  = 1'b0;
  logic hold_used = 1'b0;
  int   hold_left = 0;
  int   offered_count = 0;
  logic last_a = 1'b1;

  always #4 clk = ~clk;

  rotary_encoder_with_button dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rotary_encoder_with_button_checker checker_i (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .mismatch_count, .pending_results
  );

  // Long receiver hold-off, once, when the stimulus asks for it
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Result-side backpressure
  always @(posedge clk) begin
    out_stall <= (hold_left > 1) || (stall_pct != 0 && $urandom_range(99) < stall_pct);
  end

  // Run limit
  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < LIMIT_CYCLES; cycles++) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic in_item_t pins(logic a, logic b, logic btn);
    in_item_t t;
    t.operation  = OP_SAMPLE;
    t.pin_a      = a;
    t.pin_b      = b;
    t.pin_button = btn;
    return t;
  endfunction

  // Status read; pin levels ride along and must be ignored
  function automatic in_item_t status_read();
    in_item_t t;
    t            = in_item_t'(4'($urandom_range(15)));
    t.operation  = OP_READ;
    return t;
  endfunction

  // Offer one transaction, with random idle cycles ahead of it
  task automatic offer_item(in_item_t it);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (it.operation == OP_SAMPLE) last_a = it.pin_a;
    offered_count++;
  endtask

  task automatic apb_access(logic wr, logic [CFG_ADDR_W-1:0] addr,
                            logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stop offering, wait out every pending report and the pipeline tail;
  // the count is looked at mid-cycle, after the checker has updated it
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(logic [CFG_DATA_W-1:0] mode_word);
    drain();
    apb_access(1'b1, DIR_MODE_ADDR, mode_word);
    apb_access(1'b0, DIR_MODE_ADDR, '0);
  endtask

  // Mostly well-formed detents and clicks, plus reads and raw noise
  task automatic random_traffic(int n);
    int   target;
    int   pick;
    int   k;
    logic bdir;
    logic held;
    logic a;
    target = offered_count + n;
    while (offered_count < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        // one detent of quadrature, button maybe held
        bdir = 1'($urandom_range(1));
        held = ($urandom_range(99) < 30);
        offer_item(pins(1'b0, bdir, ~held ^ ($urandom_range(9) == 0)));
        offer_item(pins(1'b0, ~bdir, ~held ^ ($urandom_range(9) == 0)));
        offer_item(pins(1'b1, ~bdir, ~held ^ ($urandom_range(9) == 0)));
        offer_item(pins(1'b1, bdir, ~held ^ ($urandom_range(9) == 0)));
      end else if (pick < 65) begin
        // press and release with A steady
        a = last_a;
        for (k = $urandom_range(1, 3); k > 0; k--)
          offer_item(pins(a, 1'($urandom_range(1)), 1'b0));
        for (k = $urandom_range(1, 2); k > 0; k--)
          offer_item(pins(a, 1'($urandom_range(1)), 1'b1));
      end else if (pick < 85) begin
        offer_item(status_read());
      end else begin
        offer_item(in_item_t'(4'($urandom_range(15))));
      end
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register reset value, ignored spare address
    apb_access(1'b0, DIR_MODE_ADDR, '0);
    apb_access(1'b1, SPARE_ADDR, '1);
    apb_access(1'b0, DIR_MODE_ADDR, '0);

    // directed: idle read, both directions, wrap below zero
    offer_item(status_read());
    offer_item(pins(1'b0, 1'b1, 1'b1));
    offer_item(status_read());
    offer_item(pins(1'b1, 1'b0, 1'b1));
    offer_item(pins(1'b0, 1'b0, 1'b1));
    offer_item(pins(1'b1, 1'b1, 1'b0));
    offer_item(pins(1'b0, 1'b0, 1'b1));
    offer_item(status_read());
    // click
    offer_item(pins(1'b1, 1'b1, 1'b0));
    offer_item(pins(1'b1, 1'b1, 1'b0));
    offer_item(pins(1'b1, 1'b1, 1'b1));
    offer_item(status_read());
    // turns while held, then release
    offer_item(pins(1'b0, 1'b1, 1'b0));
    offer_item(status_read());
    offer_item(pins(1'b1, 1'b0, 1'b0));
    offer_item(pins(1'b0, 1'b0, 1'b0));
    offer_item(status_read());
    offer_item(status_read());
    offer_item(pins(1'b0, 1'b0, 1'b1));
    offer_item(status_read());
    // pending click beats a turn, difference still absorbed
    offer_item(pins(1'b0, 1'b1, 1'b0));
    offer_item(pins(1'b0, 1'b0, 1'b1));
    offer_item(pins(1'b1, 1'b0, 1'b1));
    offer_item(pins(1'b0, 1'b1, 1'b1));
    offer_item(status_read());
    offer_item(status_read());

    // random, no idling
    random_traffic(500);

    // sender idles, mode 0
    reconfigure(32'hFFFF_FFFE);
    idle_pct = 45;
    random_traffic(500);

    // receiver stalls, mode 1
    reconfigure(32'h0000_0001);
    idle_pct  = 0;
    stall_pct = 45;
    random_traffic(500);

    // light idling on both sides plus a long receiver hold-off, mode 0
    reconfigure('0);
    idle_pct  = 6;
    stall_pct = 6;
    hold_req <= 1'b1;
    random_traffic(500);

    drain();
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
